/* src/ftx_pkg.sv */
`timescale 1ns / 1ps

package ftx_pkg;

    // result kinds
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_WOKEN    = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    // request operations
    localparam logic OP_WAIT = 1'b0;
    localparam logic OP_WAKE = 1'b1;

    localparam int KIND_W    = 2;
    localparam int THREAD_W  = 16;
    localparam int ADDR_W    = 64;
    localparam int MASK_W    = 32;
    localparam int WCOUNT_W  = 5;
    localparam int IN_DATA_W = THREAD_W + ADDR_W + MASK_W;
    // woken_thread and wake_count, padded to whole bytes
    localparam int OUT_DATA_W = 24;

    // one stored waiter
    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [MASK_W-1:0]   mask;
        logic [THREAD_W-1:0] thread;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/ftx_ram.sv */
`timescale 1ns / 1ps

module ftx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/futex_waiter_table.sv */
`timescale 1ns / 1ps

// Futex waiter table: keeps up to WAITERS waiting threads (address, 32-bit
// mask, thread id) in arrival order in a single-port-read RAM. A wait request
// appends an entry and answers accepted, or rejected when the table is full;
// the block is ready again once its result leaves the output register. A
// wake request walks the stored entries one per cycle through the RAM read
// port, pausing on a match while the output stalls, compacting survivors in
// place, emits one woken result per matching entry and then a done result
// with the count (tlast set). The block takes no new request during a wake.
// The table needs no clearing after reset: only slots below the fill count
// are ever used.
module futex_waiter_table #(
    parameter int WAITERS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // thread_id[15:0], wait_address[79:16], wait_mask[111:80]
    input  logic [ftx_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation[0]
    input  logic                             s_tuser,
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // woken_thread[15:0], wake_count[20:16], zero pad[23:21]
    output logic [ftx_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic [ftx_pkg::KIND_W-1:0]       m_tuser,
    output logic                             m_tlast
);

    import ftx_pkg::*;

    localparam int IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int CW = $clog2(WAITERS + 1);
    localparam logic [CW-1:0] FULL = CW'(WAITERS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_reg, rd_next;
    logic [CW-1:0]       wr_reg, wr_next;
    logic [CW-1:0]       woken_reg, woken_next;
    logic [ADDR_W-1:0]   key_addr_reg, key_addr_next;
    logic [MASK_W-1:0]   key_mask_reg, key_mask_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [THREAD_W-1:0] out_thread_reg, out_thread_next;
    logic [WCOUNT_W-1:0] out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    entry_t              in_entry;
    entry_t              rd_entry;
    entry_t              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;

    logic                out_free;
    logic                accept;
    logic                hit;
    logic                scan_last;

    // request payload unpacking
    assign in_entry.thread  = s_tdata[THREAD_W-1:0];
    assign in_entry.address = s_tdata[THREAD_W+ADDR_W-1:THREAD_W];
    assign in_entry.mask    = s_tdata[IN_DATA_W-1:THREAD_W+ADDR_W];

    assign rd_entry = entry_t'(ram_rdata);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // shared compare unit: address equality and mask overlap
    assign hit = (rd_entry.address == key_addr_reg) &&
                 ((rd_entry.mask & key_mask_reg) != '0);
    assign scan_last = ((rd_reg + CW'(1)) == count_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        woken_next      = woken_reg;
        key_addr_next   = key_addr_reg;
        key_mask_next   = key_mask_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_thread_next = out_thread_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IW-1:0];
        ram_wdata       = in_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = '0;
                    out_count_next  = '0;
                    out_last_next   = 1'b1;
                    if (s_tuser == OP_WAIT)
                    begin
                        if (count_reg >= FULL)
                        begin
                            out_kind_next = KIND_REJECTED;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            count_next    = count_reg + CW'(1);
                            out_kind_next = KIND_ACCEPTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_kind_next = KIND_DONE;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        key_addr_next  = in_entry.address;
                        key_mask_next  = in_entry.mask;
                        rd_next        = '0;
                        wr_next        = '0;
                        woken_next     = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_WOKEN;
                        out_thread_next = rd_entry.thread;
                        out_count_next  = '0;
                        out_last_next   = 1'b0;
                        woken_next      = woken_reg + CW'(1);
                        rd_next         = rd_reg + CW'(1);
                        if (scan_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
                else
                begin
                    // keep survivor, moved down over removed slots
                    ram_we    = (wr_reg != rd_reg);
                    ram_waddr = wr_reg[IW-1:0];
                    ram_wdata = rd_entry;
                    wr_next   = wr_reg + CW'(1);
                    rd_next   = rd_reg + CW'(1);
                    if (scan_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DONE;
                    out_thread_next = '0;
                    out_count_next  = WCOUNT_W'(woken_reg);
                    out_last_next   = 1'b1;
                    count_next      = wr_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // waiter storage
    ftx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WAITERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_next[IW-1:0]),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        woken_reg      <= woken_next;
        key_addr_reg   <= key_addr_next;
        key_mask_reg   <= key_mask_next;
        out_kind_reg   <= out_kind_next;
        out_thread_reg <= out_thread_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - THREAD_W - WCOUNT_W){1'b0}},
                       out_count_reg, out_thread_reg};

    // fill count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count beyond table depth");

    // compaction never writes ahead of the read pointer
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg))
        else $error("compaction write pointer passed read pointer");

    // a woken result is never the last one of a wake
    a_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_WOKEN)) |-> !m_tlast)
        else $error("woken result marked last");

    // a wake never grows the table
    a_wake_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=> (count_reg <= $past(count_reg)))
        else $error("wake increased fill count");

endmodule

/* dv/futex_waiter_checker.sv */
`timescale 1ns / 1ps

module futex_waiter_checker #(
    parameter int WAITERS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // thread_id, wait_address, wait_mask
    input  logic [ftx_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // woken_thread, wake_count, zero pad
    input  logic [ftx_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind
    input  logic [ftx_pkg::KIND_W-1:0]       m_tuser,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               pending
);

    import ftx_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [THREAD_W-1:0] thread;
        logic [WCOUNT_W-1:0] count;
        logic                last;
    } outcome_t;

    // waiters in arrival order, and results still owed by the block
    entry_t   waiters[$];
    outcome_t owed_results[$];

    function automatic outcome_t make_outcome(input logic [KIND_W-1:0] kind,
                                              input logic [THREAD_W-1:0] thread,
                                              input logic [WCOUNT_W-1:0] count,
                                              input logic last);
        outcome_t o;
        o.kind   = kind;
        o.thread = thread;
        o.count  = count;
        o.last   = last;
        return o;
    endfunction

    // apply one request to the waiter list and queue the results it causes
    task automatic predict_request(input logic op,
                                   input logic [THREAD_W-1:0] tid,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic [MASK_W-1:0] mask);
        entry_t kept[$];
        entry_t fresh;
        int     woken;
        woken = 0;
        if (op == OP_WAIT)
        begin
            if (waiters.size() >= WAITERS)
                owed_results.insert(owed_results.size(),
                                    make_outcome(KIND_REJECTED, '0, '0, 1'b1));
            else
            begin
                fresh.address = addr;
                fresh.mask    = mask;
                fresh.thread  = tid;
                waiters.insert(waiters.size(), fresh);
                owed_results.insert(owed_results.size(),
                                    make_outcome(KIND_ACCEPTED, '0, '0, 1'b1));
            end
        end
        else
        begin
            // matching waiters leave in order, the rest keep their order
            foreach (waiters[i])
            begin
                if (waiters[i].address == addr && (waiters[i].mask & mask) != '0)
                begin
                    owed_results.insert(owed_results.size(),
                                        make_outcome(KIND_WOKEN, waiters[i].thread,
                                                     '0, 1'b0));
                    woken++;
                end
                else
                    kept.insert(kept.size(), waiters[i]);
            end
            waiters = kept;
            owed_results.insert(owed_results.size(),
                                make_outcome(KIND_DONE, '0, WCOUNT_W'(woken), 1'b1));
        end
    endtask

    // results are checked before new requests are predicted in the same cycle
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            waiters.delete();
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            got = make_outcome(m_tuser, m_tdata[THREAD_W-1:0],
                               m_tdata[THREAD_W +: WCOUNT_W], m_tlast);
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind %0d thread %h count %0d last %b",
                                 $time, got.kind, got.thread, got.count, got.last);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.kind !== want.kind || got.thread !== want.thread ||
                        got.count !== want.count || got.last !== want.last ||
                        m_tdata[OUT_DATA_W-1:THREAD_W+WCOUNT_W] !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch: expected kind %0d thread %h %s",
                                     $time, want.kind, want.thread, "");
                            $display("%0t:   expected count %0d last %b",
                                     $time, want.count, want.last);
                            $display("%0t:   got kind %0d thread %h count %0d last %b pad %b",
                                     $time, got.kind, got.thread, got.count, got.last,
                                     m_tdata[OUT_DATA_W-1:THREAD_W+WCOUNT_W]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[THREAD_W-1:0], s_tdata[THREAD_W +: ADDR_W],
                                s_tdata[THREAD_W+ADDR_W +: MASK_W]);
            pending <= owed_results.size();
        end
    end

endmodule

/* dv/tb_futex_waiter_table.sv */
`timescale 1ns / 1ps

module tb_futex_waiter_table;

    import ftx_pkg::*;

    localparam int WAITERS      = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = WAITERS + 20;
    localparam int HOT_ADDRS    = 4;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = OP_WAIT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    int mismatches;
    int pending;
    int send_idle_pct = 15;
    int recv_idle_pct = 87;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int cycles;

    logic [ADDR_W-1:0] hot_addr[HOT_ADDRS];

    futex_waiter_table #(
        .WAITERS (WAITERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    futex_waiter_checker #(
        .WAITERS (WAITERS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_futex_waiter_table: FAIL");
            $finish;
        end
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input logic op,
                                input logic [THREAD_W-1:0] tid,
                                input logic [ADDR_W-1:0] addr,
                                input logic [MASK_W-1:0] mask);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {mask, addr, tid};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering until every owed result has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // mostly the shared futex words, sometimes any address
    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(99) < 88)
            return hot_addr[$urandom_range(HOT_ADDRS-1)];
        return {$urandom, $urandom};
    endfunction

    // zero only for wakes, and rarely
    function automatic logic [MASK_W-1:0] pick_mask(input logic for_wake);
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return MASK_W'(1) << $urandom_range(MASK_W-1);
            7:          return '1;
            8:          return $urandom & $urandom;
            default:    return for_wake ? '0 : MASK_W'($urandom | 1);
        endcase
    endfunction

    task automatic random_requests(input int n);
        logic op;
        repeat (n)
        begin
            op = ($urandom_range(99) < 55) ? OP_WAIT : OP_WAKE;
            send_request(op, THREAD_W'($urandom), pick_addr(), pick_mask(op == OP_WAKE));
        end
    endtask

    initial
    begin
        foreach (hot_addr[i])
            hot_addr[i] = {$urandom, $urandom};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wake on an empty table
        send_request(OP_WAKE, 16'h0000, hot_addr[0], '1);
        // zero wait mask: stored but never selectable
        send_request(OP_WAIT, 16'h0000, '0, '0);
        send_request(OP_WAKE, 16'hffff, '0, '1);
        // field extremes
        send_request(OP_WAIT, 16'hffff, '1, '1);
        send_request(OP_WAIT, 16'h1234, '1, 32'h8000_0000);
        // same thread waiting twice, with a survivor behind it
        send_request(OP_WAIT, 16'h0007, hot_addr[0], 32'h0000_0001);
        send_request(OP_WAIT, 16'h0007, hot_addr[0], 32'h0000_0001);
        send_request(OP_WAIT, 16'h00a5, hot_addr[0], 32'h0000_0002);
        // zero wake mask, then selective wakes
        send_request(OP_WAKE, 16'h0000, '1, '0);
        send_request(OP_WAKE, 16'h0000, '1, 32'h0000_0001);
        send_request(OP_WAKE, 16'h0000, '1, 32'h8000_0000);
        send_request(OP_WAKE, 16'h0000, hot_addr[0], 32'h0000_0001);
        send_request(OP_WAKE, 16'h0000, hot_addr[1], '1);
        send_request(OP_WAKE, 16'h0000, hot_addr[0], '1);
        wait_for_results();

        random_requests(24);
        wait_for_results();

        send_idle_pct = 87;
        recv_idle_pct = 15;
        random_requests(24);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while the table fills and overflows
        hold_asks = hold_asks + 1;
        repeat (WAITERS + 2)
            send_request(OP_WAIT, THREAD_W'($urandom), hot_addr[$urandom_range(HOT_ADDRS-1)],
                         pick_mask(1'b0) | MASK_W'(1));
        wait_for_results();
        // one wake per hot address, each draining many waiters at once
        foreach (hot_addr[i])
            send_request(OP_WAKE, THREAD_W'($urandom), hot_addr[i], '1);
        random_requests(24);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_futex_waiter_table: PASS");
        else
            $display("tb_futex_waiter_table: FAIL");
        $finish;
    end

endmodule
